@@ sv/assert_macros.svh @@
// Assertion macros shared by the block's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/hge_pkg.sv @@
// Shared types and constants of the hash grid encoder.
package hge_pkg;

    localparam int MAX_LEVELS    = 16;
    localparam int LEVEL_BITS    = 4;
    localparam int ADDR_BITS     = 20;
    localparam int FEAT_BITS     = 16;
    localparam int FRAC_BITS     = 16;
    localparam int ACC_BITS      = 36;
    localparam logic [31:0] PRIME_Y = 32'd2654435761;
    localparam logic [31:0] PRIME_Z = 32'd805459861;

    localparam logic [1:0] CMD_WRITE_DESC = 2'd0;
    localparam logic [1:0] CMD_WRITE_FEAT = 2'd1;
    localparam logic [1:0] CMD_ENCODE     = 2'd2;

    typedef enum logic [4:0] {
        OP_IDLE, OP_DESC, OP_PX, OP_PY, OP_PZ, OP_R2, OP_R3, OP_HSEL,
        OP_I1, OP_I2, OP_W1, OP_W2, OP_W3, OP_MODW, OP_RD, OP_FMUL,
        OP_ACC, OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t                op;
        logic [LEVEL_BITS-1:0] lv;
        logic [2:0]            corner;
        logic                  wr_desc;
        logic                  wr_feat;
        logic                  load_point;
        logic                  last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mod_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ sv/hge_mod.sv @@
// Remainder unit: 32-bit dividend modulo 21-bit divisor, four bits a cycle.
module hge_mod
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [20:0] divisor,
    output logic        done,
    output logic [20:0] remainder
);

    logic [31:0] dvd_reg, dvd_next;
    logic [20:0] dvs_reg;
    logic [20:0] rem_reg, rem_next;
    logic [2:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    always_comb
    begin
        logic [21:0] r;
        r        = {1'b0, rem_reg};
        dvd_next = dvd_reg;
        for (int i = 0; i < 4; i++)
        begin
            r        = {r[20:0], dvd_next[31]};
            dvd_next = {dvd_next[30:0], 1'b0};
            if (r >= {1'b0, dvs_reg})
            begin
                r = r - {1'b0, dvs_reg};
            end
        end
        rem_next = r[20:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = (dvs_reg == '0) ? '0 : rem_reg;

endmodule

@@ sv/hge_dp.sv @@
// Datapath: level tables, feature memory, shared multiplier and blend accumulators.
module hge_dp
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  hge_pkg::ctrl_cmd_t       cmd,
    output hge_pkg::dp_status_t      status,
    input  logic [3:0]               level,
    input  logic [19:0]              entry_address,
    input  logic signed [15:0]       feature_zero,
    input  logic signed [15:0]       feature_one,
    input  logic [11:0]              grid_scale,
    input  logic [12:0]              grid_resolution,
    input  logic [20:0]              table_size,
    input  logic [19:0]              table_base,
    input  logic [15:0]              coord_x,
    input  logic [15:0]              coord_y,
    input  logic [15:0]              coord_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [3:0]               out_level,
    output logic signed [15:0]       encoded_zero,
    output logic signed [15:0]       encoded_one,
    output logic                     last_level
);

    logic [11:0] scale_tab [hge_pkg::MAX_LEVELS];
    logic [12:0] res_tab   [hge_pkg::MAX_LEVELS];
    logic [20:0] size_tab  [hge_pkg::MAX_LEVELS];
    logic [19:0] base_tab  [hge_pkg::MAX_LEVELS];
    logic [31:0] feat_mem  [2**hge_pkg::ADDR_BITS];

    logic [15:0] cx_reg, cy_reg, cz_reg;
    logic [11:0] scale_reg;
    logic [12:0] res_reg;
    logic [20:0] size_reg;
    logic [19:0] tbase_reg;
    logic [25:0] res2_reg;
    logic        hash_reg;
    logic [11:0] bc_reg [3];
    logic [15:0] fr_reg [3];
    logic [31:0] t1_reg;
    logic [16:0] w_reg;
    logic [19:0] addr_reg;
    logic [31:0] rd_reg;
    logic signed [33:0] fp0_reg, fp1_reg;
    logic signed [hge_pkg::ACC_BITS-1:0] acc0_reg, acc1_reg;
    logic [63:0] mul_q_reg;
    logic [31:0] mul_a, mul_b;

    logic        ov_reg;
    logic [3:0]  olv_reg;
    logic signed [15:0] oe0_reg, oe1_reg;
    logic        olast_reg;

    logic [16:0] comp [3];
    logic [12:0] c0, c1, c2;
    logic [16:0] fx, fy, fz;
    logic [27:0] p_sum;
    logic [33:0] rnd;
    logic [31:0] idx;
    logic        mod_start;
    logic        mod_done;
    logic [20:0] mod_rem;
    logic signed [15:0] fin0, fin1;

    function automatic logic signed [15:0] finish(input logic signed [35:0] a);
        logic signed [35:0] s;
        logic signed [19:0] r;
        s = a + 36'sd32768;
        r = 20'(s >>> hge_pkg::FRAC_BITS);
        if (r > 20'sd32767)
        begin
            return 16'sd32767;
        end
        else if (r < -20'sd32768)
        begin
            return -16'sd32768;
        end
        return r[15:0];
    endfunction

    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            comp[d] = 17'h10000 - {1'b0, fr_reg[d]};
        end
        c0 = {1'b0, bc_reg[0]} + {12'd0, cmd.corner[2]};
        c1 = {1'b0, bc_reg[1]} + {12'd0, cmd.corner[1]};
        c2 = {1'b0, bc_reg[2]} + {12'd0, cmd.corner[0]};
        fx = cmd.corner[2] ? {1'b0, fr_reg[0]} : comp[0];
        fy = cmd.corner[1] ? {1'b0, fr_reg[1]} : comp[1];
        fz = cmd.corner[0] ? {1'b0, fr_reg[2]} : comp[2];
        p_sum = mul_q_reg[27:0] + 28'h8000;
        rnd   = mul_q_reg[33:0] + 34'h8000;
        idx   = hash_reg ? ({19'd0, c0} ^ t1_reg ^ mul_q_reg[31:0])
                         : ({19'd0, c0} + t1_reg + mul_q_reg[31:0]);
        fin0  = finish(acc0_reg);
        fin1  = finish(acc1_reg);
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            hge_pkg::OP_PX:
            begin
                mul_a = {16'd0, cx_reg};
                mul_b = {20'd0, scale_reg};
            end
            hge_pkg::OP_PY:
            begin
                mul_a = {16'd0, cy_reg};
                mul_b = {20'd0, scale_reg};
            end
            hge_pkg::OP_PZ:
            begin
                mul_a = {16'd0, cz_reg};
                mul_b = {20'd0, scale_reg};
            end
            hge_pkg::OP_R2:
            begin
                mul_a = {19'd0, res_reg};
                mul_b = {19'd0, res_reg};
            end
            hge_pkg::OP_R3:
            begin
                mul_a = mul_q_reg[31:0];
                mul_b = {19'd0, res_reg};
            end
            hge_pkg::OP_I1:
            begin
                mul_a = {19'd0, c1};
                mul_b = hash_reg ? hge_pkg::PRIME_Y : {19'd0, res_reg};
            end
            hge_pkg::OP_I2:
            begin
                mul_a = {19'd0, c2};
                mul_b = hash_reg ? hge_pkg::PRIME_Z : {6'd0, res2_reg};
            end
            hge_pkg::OP_W1:
            begin
                mul_a = {15'd0, fx};
                mul_b = {15'd0, fy};
            end
            hge_pkg::OP_W2:
            begin
                mul_a = {15'd0, rnd[32:16]};
                mul_b = {15'd0, fz};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mod_start = (cmd.op == hge_pkg::OP_W1);

    hge_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (idx),
        .divisor   (size_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_ff @(posedge clk)
    begin
        mul_q_reg <= mul_a * mul_b;
        if (cmd.wr_desc)
        begin
            scale_tab[level] <= grid_scale;
            res_tab[level]   <= grid_resolution;
            size_tab[level]  <= table_size;
            base_tab[level]  <= table_base;
        end
        if (cmd.wr_feat)
        begin
            feat_mem[entry_address] <= {feature_one, feature_zero};
        end
        if (cmd.load_point)
        begin
            cx_reg <= coord_x;
            cy_reg <= coord_y;
            cz_reg <= coord_z;
        end
        unique case (cmd.op)
            hge_pkg::OP_DESC:
            begin
                scale_reg <= scale_tab[cmd.lv];
                res_reg   <= res_tab[cmd.lv];
                size_reg  <= size_tab[cmd.lv];
                tbase_reg <= base_tab[cmd.lv];
            end
            hge_pkg::OP_PY:
            begin
                bc_reg[0] <= p_sum[27:16];
                fr_reg[0] <= p_sum[15:0];
            end
            hge_pkg::OP_PZ:
            begin
                bc_reg[1] <= p_sum[27:16];
                fr_reg[1] <= p_sum[15:0];
            end
            hge_pkg::OP_R2:
            begin
                bc_reg[2] <= p_sum[27:16];
                fr_reg[2] <= p_sum[15:0];
            end
            hge_pkg::OP_R3:
            begin
                res2_reg <= mul_q_reg[25:0];
            end
            hge_pkg::OP_HSEL:
            begin
                hash_reg <= (mul_q_reg[39:0] > {19'd0, size_reg});
                acc0_reg <= '0;
                acc1_reg <= '0;
            end
            hge_pkg::OP_I2:
            begin
                t1_reg <= mul_q_reg[31:0];
            end
            hge_pkg::OP_W3:
            begin
                w_reg <= rnd[32:16];
            end
            hge_pkg::OP_MODW:
            begin
                addr_reg <= tbase_reg + mod_rem[19:0];
            end
            hge_pkg::OP_RD:
            begin
                rd_reg <= feat_mem[addr_reg];
            end
            hge_pkg::OP_FMUL:
            begin
                fp0_reg <= $signed({1'b0, w_reg}) * $signed(rd_reg[15:0]);
                fp1_reg <= $signed({1'b0, w_reg}) * $signed(rd_reg[31:16]);
            end
            hge_pkg::OP_ACC:
            begin
                acc0_reg <= acc0_reg + 36'(fp0_reg);
                acc1_reg <= acc1_reg + 36'(fp1_reg);
            end
            default:
            begin
            end
        endcase
        if (cmd.op == hge_pkg::OP_OUT && status.out_free)
        begin
            olv_reg   <= cmd.lv;
            oe0_reg   <= fin0;
            oe1_reg   <= fin1;
            olast_reg <= cmd.last;
        end
    end

    // result register: load on a free slot, drop once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.op == hge_pkg::OP_OUT && status.out_free)
        begin
            ov_reg <= 1'b1;
        end
        else if (ov_reg && !out_stall)
        begin
            ov_reg <= 1'b0;
        end
    end

    assign status.mod_done = mod_done;
    assign status.out_free = !ov_reg || !out_stall;

    assign out_valid    = ov_reg;
    assign out_level    = olv_reg;
    assign encoded_zero = oe0_reg;
    assign encoded_one  = oe1_reg;
    assign last_level   = olast_reg;

endmodule

@@ sv/hge_ctrl.sv @@
// Controller: command decode, level and corner sequencing, level count register.
module hge_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           command,
    input  logic                 cfg_write_enable,
    input  logic [4:0]           cfg_data,
    input  hge_pkg::dp_status_t  status,
    output hge_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [4:0] {
        IDLE, DESC, PX, PY, PZ, R2, R3, HSEL, I1, I2, W1, W2, W3,
        MODW, RD, FMUL, ACC, OUTP
    } state_t;

    state_t      state_reg;
    logic [3:0]  lv_reg;
    logic [2:0]  corner_reg;
    logic [4:0]  levels_reg;
    logic [4:0]  n_lv;
    logic        accept;
    logic        last;

    assign accept = in_valid && (state_reg == IDLE);
    assign in_stall = (state_reg != IDLE);

    always_comb
    begin
        priority if (levels_reg == 5'd0)
        begin
            n_lv = 5'd1;
        end
        else if (levels_reg > 5'(hge_pkg::MAX_LEVELS))
        begin
            n_lv = 5'(hge_pkg::MAX_LEVELS);
        end
        else
        begin
            n_lv = levels_reg;
        end
    end

    assign last = ({1'b0, lv_reg} == (n_lv - 5'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            lv_reg     <= '0;
            corner_reg <= '0;
            levels_reg <= 5'(hge_pkg::MAX_LEVELS);
        end
        else
        begin
            if (cfg_write_enable)
            begin
                levels_reg <= cfg_data;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (accept && command == hge_pkg::CMD_ENCODE)
                    begin
                        lv_reg    <= '0;
                        state_reg <= DESC;
                    end
                end
                DESC: state_reg <= PX;
                PX:   state_reg <= PY;
                PY:   state_reg <= PZ;
                PZ:   state_reg <= R2;
                R2:   state_reg <= R3;
                R3:   state_reg <= HSEL;
                HSEL:
                begin
                    corner_reg <= '0;
                    state_reg  <= I1;
                end
                I1:   state_reg <= I2;
                I2:   state_reg <= W1;
                W1:   state_reg <= W2;
                W2:   state_reg <= W3;
                W3:   state_reg <= MODW;
                MODW:
                begin
                    if (status.mod_done)
                    begin
                        state_reg <= RD;
                    end
                end
                RD:   state_reg <= FMUL;
                FMUL: state_reg <= ACC;
                ACC:
                begin
                    if (corner_reg == 3'd7)
                    begin
                        state_reg <= OUTP;
                    end
                    else
                    begin
                        corner_reg <= corner_reg + 3'd1;
                        state_reg  <= I1;
                    end
                end
                OUTP:
                begin
                    if (status.out_free)
                    begin
                        if (last)
                        begin
                            state_reg <= IDLE;
                        end
                        else
                        begin
                            lv_reg    <= lv_reg + 4'd1;
                            state_reg <= DESC;
                        end
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd.lv         = lv_reg;
        cmd.corner     = corner_reg;
        cmd.last       = last;
        cmd.wr_desc    = accept && (command == hge_pkg::CMD_WRITE_DESC);
        cmd.wr_feat    = accept && (command == hge_pkg::CMD_WRITE_FEAT);
        cmd.load_point = accept && (command == hge_pkg::CMD_ENCODE);
        unique case (state_reg)
            IDLE:    cmd.op = hge_pkg::OP_IDLE;
            DESC:    cmd.op = hge_pkg::OP_DESC;
            PX:      cmd.op = hge_pkg::OP_PX;
            PY:      cmd.op = hge_pkg::OP_PY;
            PZ:      cmd.op = hge_pkg::OP_PZ;
            R2:      cmd.op = hge_pkg::OP_R2;
            R3:      cmd.op = hge_pkg::OP_R3;
            HSEL:    cmd.op = hge_pkg::OP_HSEL;
            I1:      cmd.op = hge_pkg::OP_I1;
            I2:      cmd.op = hge_pkg::OP_I2;
            W1:      cmd.op = hge_pkg::OP_W1;
            W2:      cmd.op = hge_pkg::OP_W2;
            W3:      cmd.op = hge_pkg::OP_W3;
            MODW:    cmd.op = hge_pkg::OP_MODW;
            RD:      cmd.op = hge_pkg::OP_RD;
            FMUL:    cmd.op = hge_pkg::OP_FMUL;
            ACC:     cmd.op = hge_pkg::OP_ACC;
            OUTP:    cmd.op = hge_pkg::OP_OUT;
            default: cmd.op = hge_pkg::OP_IDLE;
        endcase
    end

endmodule

@@ sv/hash_grid_encoder_unit.sv @@
// Top level of the multiresolution hash grid encoder.
// Input channel (in_valid/in_stall) carries one command per beat: write a
// level descriptor, write a feature entry, or encode a point. An encode
// yields one result beat per level in use on the output channel
// (out_valid/out_stall), last_level set on the final one. Each level runs
// descriptor fetch and scaling, then per corner the shared multiplier,
// the remainder unit and the single feature memory port. The input is
// stalled for the whole encode and taken again once the last result
// sits in the output register. A stalled receiver holds the result
// register and the sequencer waits before loading the next level's beat.
// cfg_write_enable writes levels_in_use (zero counts as one, above sixteen
// as sixteen); write it only while idle. Reset sets levels_in_use to
// sixteen and empties the result register; descriptor and feature stores
// hold nothing defined until written.
module hash_grid_encoder_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [3:0]         level,
    input  logic [19:0]        entry_address,
    input  logic signed [15:0] feature_zero,
    input  logic signed [15:0] feature_one,
    input  logic [11:0]        grid_scale,
    input  logic [12:0]        grid_resolution,
    input  logic [20:0]        table_size,
    input  logic [19:0]        table_base,
    input  logic [15:0]        coord_x,
    input  logic [15:0]        coord_y,
    input  logic [15:0]        coord_z,
    input  logic               cfg_write_enable,
    input  logic [4:0]         cfg_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         out_level,
    output logic signed [15:0] encoded_zero,
    output logic signed [15:0] encoded_one,
    output logic               last_level
);

`include "assert_macros.svh"

    hge_pkg::ctrl_cmd_t  cmd;
    hge_pkg::dp_status_t status;

    hge_ctrl u_ctrl
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .cfg_write_enable (cfg_write_enable),
        .cfg_data         (cfg_data),
        .status           (status),
        .cmd              (cmd)
    );

    hge_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .level           (level),
        .entry_address   (entry_address),
        .feature_zero    (feature_zero),
        .feature_one     (feature_one),
        .grid_scale      (grid_scale),
        .grid_resolution (grid_resolution),
        .table_size      (table_size),
        .table_base      (table_base),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .coord_z         (coord_z),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_level       (out_level),
        .encoded_zero    (encoded_zero),
        .encoded_one     (encoded_one),
        .last_level      (last_level)
    );

    `ASSERT_NEXT(a_encode_goes_busy, clk, rst_n, in_valid && !in_stall && command == hge_pkg::CMD_ENCODE, in_stall)
    `ASSERT_NEXT(a_more_levels_busy, clk, rst_n, out_valid && !out_stall && !last_level, in_stall)
    `ASSERT_SAME(a_idle_no_pending, clk, rst_n, !in_stall && out_valid, last_level)

endmodule
